[rtl/shell_comment_stripper_assert.svh]
// assertion macros for the shell comment stripper
`ifndef SHELL_COMMENT_STRIPPER_ASSERT_SVH
`define SHELL_COMMENT_STRIPPER_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define SCS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scs assertion failed");
// next-cycle implication, checked outside reset
`define SCS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scs assertion failed");
`else
`define SCS_ASSERT_NOW(name, ante, cons)
`define SCS_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[rtl/scs_pkg.sv]
`timescale 1ns / 1ps

package scs_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } scs_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       keep;
    logic       comment_start;
    logic       out_last;
  } scs_out_t;

  // decoded byte classes
  typedef struct packed {
    logic is_hash;
    logic is_dollar;
    logic is_lbrace;
    logic is_rbrace;
    logic is_dquote;
    logic is_squote;
    logic is_bslash;
    logic is_special;
  } scs_class_t;

  // per-line scan state
  typedef struct packed {
    logic quoted;
    logic quote_is_single;
    logic in_brace;
    logic backslash_odd;
    logic dollar_may_open;
    logic dollar_may_skip;
    logic comment_seen;
  } scs_state_t;

endpackage

[rtl/scs_classify.sv]
`timescale 1ns / 1ps

module scs_classify (
  input  logic [7:0]          in_byte,
  output scs_pkg::scs_class_t cls
);
  import scs_pkg::*;

  always_comb begin
    cls.is_hash    = (in_byte == CH_HASH);
    cls.is_dollar  = (in_byte == CH_DOLLAR);
    cls.is_lbrace  = (in_byte == CH_LBRACE);
    cls.is_rbrace  = (in_byte == CH_RBRACE);
    cls.is_dquote  = (in_byte == CH_DQUOTE);
    cls.is_squote  = (in_byte == CH_SQUOTE);
    cls.is_bslash  = (in_byte == CH_BSLASH);
    // special parameter bytes after an unquoted dollar
    cls.is_special = (in_byte == CH_HASH) || (in_byte == CH_QMARK) ||
                     (in_byte == CH_DOLLAR) || (in_byte == CH_STAR) ||
                     (in_byte == CH_AT) || (in_byte == CH_BANG) ||
                     ((in_byte >= CH_ZERO) && (in_byte <= CH_NINE));
  end

endmodule

[rtl/scs_scan.sv]
`timescale 1ns / 1ps

module scs_scan (
  input  scs_pkg::scs_state_t st,
  input  scs_pkg::scs_class_t cls,
  input  logic                last,
  output scs_pkg::scs_state_t st_next,
  output logic                keep,
  output logic                start
);
  import scs_pkg::*;

  logic escaped;
  logic is_quote;

  assign escaped  = st.backslash_odd;
  assign is_quote = cls.is_dquote || cls.is_squote;

  always_comb begin
    st_next = st;
    keep    = 1'b1;
    start   = 1'b0;
    if (st.comment_seen) begin
      keep = 1'b0;
    end else if (st.dollar_may_skip && cls.is_special) begin
      // special parameter byte is swallowed
      st_next.dollar_may_open = 1'b0;
      st_next.dollar_may_skip = 1'b0;
      st_next.backslash_odd   = 1'b0;
    end else begin
      if (st.dollar_may_open && cls.is_lbrace) begin
        st_next.in_brace = 1'b1;
      end else if (st.in_brace && cls.is_rbrace) begin
        st_next.in_brace = 1'b0;
      end

      if (cls.is_dollar && !st.quoted) begin
        st_next.dollar_may_open = 1'b1;
        st_next.dollar_may_skip = !st_next.in_brace;
      end else begin
        st_next.dollar_may_open = 1'b0;
        st_next.dollar_may_skip = 1'b0;
      end

      if (is_quote) begin
        if (!escaped) begin
          if (!st.quoted) begin
            st_next.quoted          = 1'b1;
            st_next.quote_is_single = cls.is_squote;
          end else if (st.quote_is_single == cls.is_squote) begin
            st_next.quoted          = 1'b0;
            st_next.quote_is_single = 1'b0;
          end
        end
      end else if (!st.quoted && !st_next.in_brace && cls.is_hash) begin
        keep                 = 1'b0;
        start                = 1'b1;
        st_next.comment_seen = 1'b1;
      end

      st_next.backslash_odd = cls.is_bslash ? !escaped : 1'b0;
    end

    if (last) begin
      st_next = '0;
    end
  end

endmodule

[rtl/shell_comment_stripper.sv]
`timescale 1ns / 1ps
// an accepted request is captured in the result register
// throughput: one byte per cycle, set by the single result register stage
//   (a new request is taken whenever the result register is empty or drained)
// reset: synchronous active-high rst clears the scan state and the result valid
// scan state also returns to its reset value after each byte marked last

module shell_comment_stripper (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  scs_pkg::scs_in_t  src_item,
  output logic              res_valid,
  input  logic              res_ready,
  output scs_pkg::scs_out_t res_item
);
  import scs_pkg::*;

`include "shell_comment_stripper_assert.svh"

  // scan state, one set of flags per line
  scs_state_t st;
  scs_state_t st_next;

  // decoded view of the incoming byte
  scs_class_t cls;

  logic keep;
  logic start;
  logic accept;

  // result register frees up when empty or being drained this cycle
  assign src_ready = !res_valid || res_ready;
  assign accept    = src_valid && src_ready;

  scs_classify u_classify (
    .in_byte (src_item.in_byte),
    .cls     (cls)
  );

  scs_scan u_scan (
    .st      (st),
    .cls     (cls),
    .last    (src_item.in_last),
    .st_next (st_next),
    .keep    (keep),
    .start   (start)
  );

  // scan state advances only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res_item.out_byte      <= src_item.in_byte;
      res_item.keep          <= keep;
      res_item.comment_start <= start;
      res_item.out_last      <= src_item.in_last;
    end
  end

  // a comment start byte is never kept
  `SCS_ASSERT_NOW(a_start_not_kept, res_valid && res_item.comment_start, !res_item.keep)
  // state clears after the last byte of a line
  `SCS_ASSERT_NEXT(a_line_clear, accept && src_item.in_last, st == '0)
  // once a comment is seen every later byte is cut
  `SCS_ASSERT_NEXT(a_after_comment, accept && st.comment_seen,
                   !res_item.keep && !res_item.comment_start)
  // an empty result register always takes a request
  `SCS_ASSERT_NOW(a_ready_when_empty, !res_valid, src_ready)

endmodule

[verif/tb_shell_comment_stripper.sv]
`timescale 1ns / 1ps

module tb_shell_comment_stripper;
  import scs_pkg::*;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         SHAPED_UNTIL = 1128;
  localparam int         NOISE_UNTIL  = 1428;

  // clock, reset and block inputs start at known values
  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     src_valid = 1'b0;
  logic     src_ready;
  scs_in_t  src_item = '0;
  logic     res_valid;
  logic     res_ready = 1'b0;
  scs_out_t res_item;

  // scan state of the predictor, kept apart from the block
  scs_state_t scan;
  // marks predicted for accepted requests, oldest first
  scs_out_t   marks_due[$];
  // bytes of the line being built by the random tests
  logic [7:0] line_buf[$];

  int  bytes_sent = 0;
  int  marks_seen = 0;
  int  fail_count = 0;
  // burst modes switch off idling on one side
  bit  src_burst = 1'b0;
  bit  res_burst = 1'b0;

  always #6 clk = ~clk;

  shell_comment_stripper dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // special parameter bytes that a bare '$' swallows
  function automatic logic is_param_char(logic [7:0] c);
    return c == CH_HASH || c == CH_QMARK || c == CH_DOLLAR || c == CH_STAR ||
           c == CH_AT || c == CH_BANG || (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  // predicts the mark of one byte and advances the scan state
  function automatic scs_out_t mark_byte(scs_in_t req);
    scs_out_t   m;
    logic [7:0] c;
    logic       escaped;
    logic       single;
    c = req.in_byte;
    m.out_byte      = c;
    m.keep          = 1'b1;
    m.comment_start = 1'b0;
    m.out_last      = req.in_last;
    if (scan.comment_seen) begin
      // everything after the comment start is cut
      m.keep = 1'b0;
    end else if (scan.dollar_may_skip && is_param_char(c)) begin
      // swallowed parameter byte: kept, no other effect
      scan.dollar_may_open = 1'b0;
      scan.dollar_may_skip = 1'b0;
      scan.backslash_odd   = 1'b0;
    end else begin
      escaped = scan.backslash_odd;
      if (scan.dollar_may_open && c == CH_LBRACE) begin
        scan.in_brace = 1'b1;
      end else if (scan.in_brace && c == CH_RBRACE) begin
        // closes the expansion even while quoted
        scan.in_brace = 1'b0;
      end
      if (c == CH_DOLLAR && !scan.quoted) begin
        scan.dollar_may_open = 1'b1;
        scan.dollar_may_skip = !scan.in_brace;
      end else begin
        scan.dollar_may_open = 1'b0;
        scan.dollar_may_skip = 1'b0;
      end
      if (c == CH_DQUOTE || c == CH_SQUOTE) begin
        single = (c == CH_SQUOTE);
        if (!escaped) begin
          if (!scan.quoted) begin
            scan.quoted          = 1'b1;
            scan.quote_is_single = single;
          end else if (scan.quote_is_single == single) begin
            scan.quoted          = 1'b0;
            scan.quote_is_single = 1'b0;
          end
        end
      end else if (!scan.quoted && !scan.in_brace && c == CH_HASH) begin
        m.keep            = 1'b0;
        m.comment_start   = 1'b1;
        scan.comment_seen = 1'b1;
      end
      scan.backslash_odd = (c == CH_BSLASH) ? !escaped : 1'b0;
    end
    // the line end clears the whole scan
    if (req.in_last) scan = '0;
    return m;
  endfunction

  // predicts on every accepted request and checks every accepted result in
  // one process, so pushing and popping never race within an edge
  always @(posedge clk) begin : monitor
    scs_out_t want;
    if (rst) begin
      scan = '0;
    end else begin
      if (src_valid && src_ready) marks_due.push_back(mark_byte(src_item));
      if (res_valid && res_ready) begin
        marks_seen++;
        if (marks_due.size() == 0) begin
          $error("result with no request waiting: out_byte %h", res_item.out_byte);
          fail_count++;
        end else begin
          want = marks_due.pop_front();
          if (res_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, res_item.out_byte);
            fail_count++;
          end
          if (res_item.keep !== want.keep) begin
            $error("keep: expected %b, actual %b", want.keep, res_item.keep);
            fail_count++;
          end
          if (res_item.comment_start !== want.comment_start) begin
            $error("comment_start: expected %b, actual %b", want.comment_start,
                   res_item.comment_start);
            fail_count++;
          end
          if (res_item.out_last !== want.out_last) begin
            $error("out_last: expected %b, actual %b", want.out_last, res_item.out_last);
            fail_count++;
          end
        end
      end
    end
  end

  // result side: a random stall before each result, none in burst mode
  initial begin : drain
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = res_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // ends a hung run: too many cycles in a row with no handshake at all
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (src_valid && src_ready) || (res_valid && res_ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  // one request; valid stays up across back-to-back requests
  task automatic send_byte(input logic [7:0] value, input logic last);
    scs_in_t req;
    int      gap;
    gap = src_burst ? 0 : $urandom_range(0, 19);
    req.in_byte = value;
    req.in_last = last;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= req;
    do @(posedge clk); while (!src_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_line_buf();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  // hold off new requests until every mark has come back
  task automatic wait_drained();
    src_valid <= 1'b0;
    wait (marks_seen >= bytes_sent);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'(CH_LOWER_A + $urandom_range(0, 25));
  endfunction

  // bytes that steer the scan, plus plain letters now and then
  function automatic logic [7:0] pick_glyph();
    case ($urandom_range(0, 12))
      0:       return CH_HASH;
      1:       return CH_DOLLAR;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      4:       return CH_DQUOTE;
      5:       return CH_SQUOTE;
      6:       return CH_BSLASH;
      7:       return CH_QMARK;
      8:       return CH_STAR;
      9:       return CH_AT;
      10:      return CH_BANG;
      11:      return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return pick_letter();
    endcase
  endfunction

  function automatic logic [7:0] pick_param();
    case ($urandom_range(0, 7))
      0:       return CH_HASH;
      1:       return CH_QMARK;
      2:       return CH_DOLLAR;
      3:       return CH_STAR;
      4:       return CH_AT;
      5:       return CH_BANG;
      6:       return 8'(CH_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // appends one shell-like token to the line, sometimes left unfinished
  task automatic add_token();
    int         n;
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 4);
        repeat (n) line_buf.push_back(pick_letter());
      end
      1: line_buf.push_back(CH_SPACE);
      2: begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        line_buf.push_back(q);
        n = $urandom_range(0, 4);
        repeat (n) line_buf.push_back(pick_glyph());
        if ($urandom_range(0, 7) != 0) line_buf.push_back(q);
      end
      3: begin
        line_buf.push_back(CH_DOLLAR);
        line_buf.push_back(CH_LBRACE);
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(pick_glyph());
        if ($urandom_range(0, 5) != 0) line_buf.push_back(CH_RBRACE);
      end
      4: begin
        line_buf.push_back(CH_DOLLAR);
        line_buf.push_back(pick_param());
      end
      5: begin
        // backslash runs of both parities ahead of a quote or a hash
        n = $urandom_range(1, 3);
        repeat (n) line_buf.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0:       line_buf.push_back(CH_DQUOTE);
          1:       line_buf.push_back(CH_SQUOTE);
          default: line_buf.push_back(CH_HASH);
        endcase
      end
      6: begin
        line_buf.push_back(CH_HASH);
        n = $urandom_range(0, 3);
        repeat (n) line_buf.push_back(pick_glyph());
      end
      7: line_buf.push_back(8'($urandom_range(0, 255)));
      default: line_buf.push_back(pick_glyph());
    endcase
  endtask

  // both byte extremes, an escaped quote, the comment start and a cut byte
  task automatic test_extremes_and_escape();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("\\\"#x");
  endtask

  // a quote left open at the line end, then a quote that cannot close
  // the other kind
  task automatic test_quote_pairing();
    send_text("'\\'#");
    send_text("\"'#\"#");
  endtask

  // swallowed special after '$', hash inside braces, brace closed while quoted
  task automatic test_dollar_and_brace();
    send_text("$#${#}#");
    send_text("${\"}\"#");
  endtask

  // mostly shell-like lines with random content, idling mixed with bursts
  task automatic test_shaped_lines();
    int n;
    while (bytes_sent < SHAPED_UNTIL) begin
      src_burst = ($urandom_range(0, 4) == 0);
      res_burst = ($urandom_range(0, 4) == 0);
      n = $urandom_range(1, 6);
      repeat (n) add_token();
      send_line_buf();
    end
    src_burst = 1'b0;
    res_burst = 1'b0;
  endtask

  // short lines of raw bytes, half of them from the steering set
  task automatic test_noise_lines();
    int n;
    while (bytes_sent < NOISE_UNTIL) begin
      src_burst = ($urandom_range(0, 5) == 0);
      res_burst = ($urandom_range(0, 5) == 0);
      n = $urandom_range(1, 8);
      repeat (n) line_buf.push_back($urandom_range(0, 1) ? pick_glyph() :
                                    8'($urandom_range(0, 255)));
      send_line_buf();
    end
    src_burst = 1'b0;
    res_burst = 1'b0;
  endtask

  initial begin : run
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_extremes_and_escape();
    test_quote_pairing();
    wait_drained();
    test_dollar_and_brace();
    test_shaped_lines();
    wait_drained();
    test_noise_lines();
    src_valid <= 1'b0;
    wait (marks_seen >= bytes_sent);
    // keep clocking to catch any stray result
    repeat (4) @(posedge clk);
    if (marks_due.size() != 0) begin
      $error("marks still expected at the end: %0d", marks_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[shell_comment_stripper.f]
+incdir+rtl
rtl/scs_pkg.sv
rtl/scs_classify.sv
rtl/scs_scan.sv
rtl/shell_comment_stripper.sv
verif/tb_shell_comment_stripper.sv
